// ===== hw/rtl/kcl_pkg.sv =====
// Shared types and constants of the keypad code lock.
package kcl_pkg;

  localparam int MAX_LEN_DEF = 16;
  localparam int KEY_W       = 4;
  localparam int STATUS_W    = 4;
  localparam int COUNT_W     = 5;

  localparam logic [KEY_W-1:0] KEY_HASH = 4'd11;

  localparam logic [STATUS_W-1:0] ST_KEY_STORED  = 4'd0;
  localparam logic [STATUS_W-1:0] ST_GRANTED     = 4'd1;
  localparam logic [STATUS_W-1:0] ST_DENIED      = 4'd2;
  localparam logic [STATUS_W-1:0] ST_OLD_OK      = 4'd3;
  localparam logic [STATUS_W-1:0] ST_OLD_WRONG   = 4'd4;
  localparam logic [STATUS_W-1:0] ST_NEW_STORED  = 4'd5;
  localparam logic [STATUS_W-1:0] ST_UNLOCK_MODE = 4'd6;
  localparam logic [STATUS_W-1:0] ST_SET_MODE    = 4'd7;
  localparam logic [STATUS_W-1:0] ST_FULL        = 4'd8;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_BUTTON,
    OP_APPEND,
    OP_FULL,
    OP_SUBMIT
  } op_t;

  typedef struct packed {
    logic latch;
    op_t  op;
    logic scan_start;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_button;
    logic is_hash;
    logic full;
    logic scan_done;
  } stat_t;

endpackage

// ===== hw/rtl/kcl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kcl_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/kcl_ctrl.sv =====
// Controller state machine: sequences accept, decode, symbol scan and result hand-off.
module kcl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  kcl_pkg::stat_t stat,
  output kcl_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.op     = kcl_pkg::OP_NONE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (stat.is_button) begin
          cmd.op     = kcl_pkg::OP_BUTTON;
          state_next = S_DONE;
        end else if (!stat.is_hash) begin
          cmd.op     = stat.full ? kcl_pkg::OP_FULL : kcl_pkg::OP_APPEND;
          state_next = S_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          cmd.op     = kcl_pkg::OP_SUBMIT;
          state_next = S_DONE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (!out_valid || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/kcl_dp.sv =====
// Datapath: entry and code stores, lengths, mode flags, symbol scan and result registers.
module kcl_dp #(
  parameter int MAX_LEN = kcl_pkg::MAX_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           mode,
  input  logic [kcl_pkg::KEY_W-1:0]      key_code,
  input  kcl_pkg::cmd_t                  cmd,
  output kcl_pkg::stat_t                 stat,
  output logic [kcl_pkg::STATUS_W-1:0]   status,
  output logic [kcl_pkg::COUNT_W-1:0]    entry_count,
  output logic                           unlock_led
);

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic                          item_mode;
  logic [kcl_pkg::KEY_W-1:0]     item_key;
  logic [LEN_W-1:0]              entry_length;
  logic [LEN_W-1:0]              stored_length;
  logic                          set_mode;
  logic                          awaiting_old;
  logic                          led;
  logic [kcl_pkg::STATUS_W-1:0]  res_status;
  logic [LEN_W-1:0]              idx;
  logic [ADDR_W-1:0]             idx_d;
  logic                          rd_valid;
  logic                          mismatch;
  logic                          copy_run;
  logic [kcl_pkg::KEY_W-1:0]     entry_rd;
  logic [kcl_pkg::KEY_W-1:0]     stored_rd;
  logic [LEN_W+kcl_pkg::COUNT_W-1:0] count_ext;

  assign count_ext = {{kcl_pkg::COUNT_W{1'b0}}, entry_length};

  assign stat.is_button = item_mode;
  assign stat.is_hash   = (item_key == kcl_pkg::KEY_HASH);
  assign stat.full      = (entry_length == LEN_W'(MAX_LEN));
  assign stat.scan_done = (idx == entry_length) && !rd_valid;

  kcl_ram #(
    .WIDTH (kcl_pkg::KEY_W),
    .DEPTH (MAX_LEN),
    .ADDR_W(ADDR_W)
  ) u_entry_ram (
    .clk    (clk),
    .wr_en  (cmd.op == kcl_pkg::OP_APPEND),
    .wr_addr(entry_length[ADDR_W-1:0]),
    .wr_data(item_key),
    .rd_addr(idx[ADDR_W-1:0]),
    .rd_data(entry_rd)
  );

  kcl_ram #(
    .WIDTH (kcl_pkg::KEY_W),
    .DEPTH (MAX_LEN),
    .ADDR_W(ADDR_W)
  ) u_code_ram (
    .clk    (clk),
    .wr_en  (copy_run && rd_valid),
    .wr_addr(idx_d),
    .wr_data(entry_rd),
    .rd_addr(idx[ADDR_W-1:0]),
    .rd_data(stored_rd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_length  <= '0;
      stored_length <= '0;
      set_mode      <= 1'b0;
      awaiting_old  <= 1'b0;
      led           <= 1'b0;
      rd_valid      <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        rd_valid <= 1'b0;
      end
      if (cmd.scan) begin
        rd_valid <= (idx != entry_length);
      end
      unique case (cmd.op)
        kcl_pkg::OP_BUTTON: begin
          set_mode     <= !set_mode;
          awaiting_old <= !set_mode;
          entry_length <= '0;
        end
        kcl_pkg::OP_APPEND: begin
          led          <= 1'b0;
          entry_length <= entry_length + LEN_W'(1);
        end
        kcl_pkg::OP_FULL: begin
          led <= 1'b0;
        end
        kcl_pkg::OP_SUBMIT: begin
          led <= !set_mode && !mismatch;
          if (set_mode && awaiting_old && !mismatch) begin
            awaiting_old <= 1'b0;
          end
          if (set_mode && !awaiting_old) begin
            stored_length <= entry_length;
          end
          entry_length <= '0;
        end
        default: ;
      endcase
    end
  end

  // item, scan and result registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_mode <= mode;
      item_key  <= key_code;
    end
    if (cmd.scan_start) begin
      idx      <= '0;
      mismatch <= (entry_length != stored_length);
      copy_run <= set_mode && !awaiting_old;
    end
    if (cmd.scan) begin
      // advance the read pointer; compare the symbol read last cycle
      if (idx != entry_length) begin
        idx_d <= idx[ADDR_W-1:0];
        idx   <= idx + LEN_W'(1);
      end
      if (rd_valid && !copy_run && (entry_rd != stored_rd)) begin
        mismatch <= 1'b1;
      end
    end
    unique case (cmd.op)
      kcl_pkg::OP_BUTTON: res_status <= set_mode ? kcl_pkg::ST_UNLOCK_MODE
                                                 : kcl_pkg::ST_SET_MODE;
      kcl_pkg::OP_APPEND: res_status <= kcl_pkg::ST_KEY_STORED;
      kcl_pkg::OP_FULL:   res_status <= kcl_pkg::ST_FULL;
      kcl_pkg::OP_SUBMIT: begin
        priority if (!set_mode) begin
          res_status <= mismatch ? kcl_pkg::ST_DENIED : kcl_pkg::ST_GRANTED;
        end else if (awaiting_old) begin
          res_status <= mismatch ? kcl_pkg::ST_OLD_WRONG : kcl_pkg::ST_OLD_OK;
        end else begin
          res_status <= kcl_pkg::ST_NEW_STORED;
        end
      end
      default: ;
    endcase
    if (cmd.emit) begin
      status      <= res_status;
      entry_count <= count_ext[kcl_pkg::COUNT_W-1:0];
      unlock_led  <= led;
    end
  end

endmodule

// ===== hw/rtl/keypad_code_lock.sv =====
// Keypad code lock with code change: controller and datapath.
//
// Input channel (in_valid/in_stall, mode, key_code): one item per key or
// mode-button press. Output channel (out_valid/out_stall, status,
// entry_count, unlock_led): exactly one result item per input item, in order.
// The lock works on one item at a time; in_stall is high from the cycle
// after acceptance until the result has moved into the output register.
// A button press or non-hash key passes from acceptance through the dispatch
// and done states into the output register, and the next item is accepted
// once the controller is back in idle. A hash key scans the entry one symbol
// per cycle through the entry and code RAMs (registered reads) in the scan
// state, up to MAX_LEN symbols, before its result moves to the done state.
// The next item may be accepted while a result waits in the output register;
// if the receiver keeps stalling, the following result is held inside and
// the input channel stalls until the output register is taken.
// Reset clears the mode to unlock, the stored code to empty, the entry and
// the LED; code and entry RAM contents are not cleared, and contents beyond
// the written length never affect a result.
module keypad_code_lock #(
  parameter int MAX_LEN = kcl_pkg::MAX_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         mode,
  input  logic [kcl_pkg::KEY_W-1:0]    key_code,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [kcl_pkg::STATUS_W-1:0] status,
  output logic [kcl_pkg::COUNT_W-1:0]  entry_count,
  output logic                         unlock_led
);

  kcl_pkg::cmd_t  cmd;
  kcl_pkg::stat_t stat;

  kcl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  kcl_dp #(
    .MAX_LEN(MAX_LEN)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .key_code   (key_code),
    .cmd        (cmd),
    .stat       (stat),
    .status     (status),
    .entry_count(entry_count),
    .unlock_led (unlock_led)
  );

endmodule

// ===== hw/rtl/kcl_check.sv =====
// Port-level checker for the keypad code lock, bound to the top level.
module kcl_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         mode,
  input logic [kcl_pkg::KEY_W-1:0]    key_code,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [kcl_pkg::STATUS_W-1:0] status,
  input logic [kcl_pkg::COUNT_W-1:0]  entry_count,
  input logic                         unlock_led
);

  // one item in flight: accepting an item closes the input channel
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again right after an item");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_count)
      && $stable(unlock_led))
    else $error("stalled result changed");

  a_granted_lights_led: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == kcl_pkg::ST_GRANTED |-> unlock_led)
    else $error("grant without LED");

  // every submit and every mode change empties the entry
  a_entry_cleared: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == kcl_pkg::ST_GRANTED || status == kcl_pkg::ST_DENIED
      || status == kcl_pkg::ST_OLD_OK || status == kcl_pkg::ST_OLD_WRONG
      || status == kcl_pkg::ST_NEW_STORED || status == kcl_pkg::ST_UNLOCK_MODE
      || status == kcl_pkg::ST_SET_MODE) |-> entry_count == '0)
    else $error("entry not cleared");

  a_led_off_on_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == kcl_pkg::ST_KEY_STORED || status == kcl_pkg::ST_FULL
      || status == kcl_pkg::ST_DENIED) |-> !unlock_led)
    else $error("LED lit after a plain key");

endmodule

bind keypad_code_lock kcl_check u_kcl_check (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for the keypad code lock: directed and random key sequences.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kcl_pkg::*;

  localparam int          LOCK_LEN     = MAX_LEN_DEF;
  localparam logic        KEYPRESS     = 1'b0;
  localparam logic        BUTTON       = 1'b1;
  localparam int          IDLE_PCT     = 28;
  localparam int          RANDOM_ITEMS = 1500;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 500_000;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                led;
  } lock_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                mode = 1'b0;
  logic [KEY_W-1:0]    key_code = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;
  logic                unlock_led;

  // Lock state as the testbench sees it
  logic [KEY_W-1:0] code_mem [LOCK_LEN];
  int unsigned      code_len;
  logic [KEY_W-1:0] entry_mem [LOCK_LEN];
  int unsigned      entry_len;
  logic             in_set_mode;
  logic             need_old_code;
  logic             led_on;

  lock_result_t lock_results_q [$];
  int           items_sent = 0;
  int           mismatch_count = 0;
  int unsigned  cycle_count = 0;
  bit           steady = 1'b0;
  int           hold_request = 0;
  int           hold_left = 0;

  keypad_code_lock u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .key_code    (key_code),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_count (entry_count),
    .unlock_led  (unlock_led)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic bit entry_matches_code();
    if (entry_len != code_len) return 1'b0;
    for (int i = 0; i < entry_len; i++) begin
      if (entry_mem[i] != code_mem[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic lock_result_t predict_result(input logic btn, input logic [KEY_W-1:0] key);
    lock_result_t res;
    if (btn) begin
      in_set_mode   = ~in_set_mode;
      need_old_code = in_set_mode;
      entry_len     = 0;
      res.status    = in_set_mode ? ST_SET_MODE : ST_UNLOCK_MODE;
    end else begin
      led_on = 1'b0;
      if (key == KEY_HASH) begin
        if (!in_set_mode) begin
          if (entry_matches_code()) begin
            res.status = ST_GRANTED;
            led_on     = 1'b1;
          end else begin
            res.status = ST_DENIED;
          end
        end else if (need_old_code) begin
          if (entry_matches_code()) begin
            res.status    = ST_OLD_OK;
            need_old_code = 1'b0;
          end else begin
            res.status = ST_OLD_WRONG;
          end
        end else begin
          for (int i = 0; i < entry_len; i++) code_mem[i] = entry_mem[i];
          code_len   = entry_len;
          res.status = ST_NEW_STORED;
        end
        entry_len = 0;
      end else if (entry_len < LOCK_LEN) begin
        entry_mem[entry_len] = key;
        entry_len++;
        res.status = ST_KEY_STORED;
      end else begin
        res.status = ST_FULL;
      end
    end
    res.count = entry_len[COUNT_W-1:0];
    res.led   = led_on;
    return res;
  endfunction

  // Any symbol that is not the submit key, including the meaningless codes
  function automatic logic [KEY_W-1:0] random_symbol();
    logic [KEY_W-1:0] sym;
    sym = KEY_W'($urandom_range(0, 14));
    if (sym >= KEY_HASH) sym = sym + 1'b1;
    return sym;
  endfunction

  // Copy the stored code, and spoil it when a mismatch is wanted
  function automatic void build_entry(ref logic [KEY_W-1:0] keys [$], input bit want_match);
    int               pos;
    logic [KEY_W-1:0] sym;
    keys.delete();
    for (int i = 0; i < code_len; i++) keys.push_back(code_mem[i]);
    if (!want_match) begin
      case ($urandom_range(0, 3))
        0: keys.push_back(random_symbol());
        1: begin
          if (keys.size() > 0) void'(keys.pop_back());
          else keys.push_back(random_symbol());
        end
        2: begin
          if (keys.size() > 0) begin
            pos = $urandom_range(0, keys.size() - 1);
            do sym = random_symbol(); while (sym == keys[pos]);
            keys[pos] = sym;
          end else begin
            keys.push_back(random_symbol());
          end
        end
        default: begin
          keys.delete();
          repeat ($urandom_range(0, 8)) keys.push_back(random_symbol());
        end
      endcase
    end
  endfunction

  task automatic send_item(input logic btn, input logic [KEY_W-1:0] key);
    @(negedge clk);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    mode     <= btn;
    key_code <= key;
    do @(posedge clk); while (in_stall);
    lock_results_q.push_back(predict_result(btn, key));
    items_sent++;
  endtask

  task automatic enter_and_submit(input logic [KEY_W-1:0] keys [$]);
    foreach (keys[i]) send_item(KEYPRESS, keys[i]);
    send_item(KEYPRESS, KEY_HASH);
  endtask

  // Receiver: random stalls, plus a long hold when a test asks for one
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    lock_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (lock_results_q.size() == 0) begin
        $error("result with none expected: status %0d count %0d led %0d",
               status, entry_count, unlock_led);
        mismatch_count++;
      end else begin
        want = lock_results_q.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatch_count++;
        end
        if (entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count);
          mismatch_count++;
        end
        if (unlock_led !== want.led) begin
          $error("unlock_led: expected %0d, got %0d", want.led, unlock_led);
          mismatch_count++;
        end
      end
    end
  end

  // After reset the code is empty, so a bare submit opens the lock
  task automatic test_empty_code();
    send_item(KEYPRESS, KEY_HASH);
  endtask

  task automatic test_entry_full();
    for (int i = 0; i < LOCK_LEN; i++) begin
      send_item(KEYPRESS, (i == KEY_HASH) ? KEY_W'(0) : KEY_W'(i));
    end
    send_item(KEYPRESS, 4'd15);
    send_item(KEYPRESS, KEY_HASH);
  endtask

  task automatic test_code_change();
    send_item(BUTTON, KEY_HASH);
    send_item(KEYPRESS, 4'd3);
    send_item(KEYPRESS, KEY_HASH);
    send_item(KEYPRESS, KEY_HASH);
    send_item(KEYPRESS, 4'd12);
    send_item(KEYPRESS, KEY_HASH);
    send_item(BUTTON, 4'd0);
    send_item(KEYPRESS, 4'd12);
    send_item(KEYPRESS, KEY_HASH);
    send_item(KEYPRESS, 4'd9);
  endtask

  task automatic test_random_sessions();
    logic [KEY_W-1:0] keys [$];
    int               pick;
    int               n;
    while (items_sent < RANDOM_ITEMS) begin
      steady = (items_sent >= 500 && items_sent < 800);
      pick   = $urandom_range(0, 99);
      keys.delete();
      if (pick < 12) begin
        // noise: any mode, any key code
        repeat ($urandom_range(1, 6)) begin
          send_item($urandom_range(0, 99) < 15, KEY_W'($urandom_range(0, 15)));
        end
      end else if (!in_set_mode) begin
        if (pick < 30) begin
          send_item(BUTTON, KEY_W'($urandom_range(0, 15)));
        end else begin
          build_entry(keys, $urandom_range(0, 99) < 60);
          enter_and_submit(keys);
        end
      end else if (need_old_code) begin
        if (pick < 20) begin
          send_item(BUTTON, KEY_W'($urandom_range(0, 15)));
        end else begin
          build_entry(keys, $urandom_range(0, 99) < 75);
          enter_and_submit(keys);
        end
      end else begin
        if (pick < 35) begin
          send_item(BUTTON, KEY_W'($urandom_range(0, 15)));
        end else begin
          pick = $urandom_range(0, 99);
          n = (pick < 70) ? $urandom_range(0, 6) :
              (pick < 95) ? $urandom_range(7, LOCK_LEN) :
                            $urandom_range(LOCK_LEN + 1, LOCK_LEN + 4);
          repeat (n) keys.push_back(random_symbol());
          enter_and_submit(keys);
        end
      end
    end
    steady = 1'b0;
  endtask

  // Hold the output long enough that the lock fills and stalls its input
  task automatic test_output_hold();
    logic [KEY_W-1:0] keys [$];
    hold_request = HOLD_CYCLES;
    repeat (10) keys.push_back(random_symbol());
    enter_and_submit(keys);
    send_item(BUTTON, 4'd5);
  endtask

  initial begin
    foreach (code_mem[i]) code_mem[i] = '0;
    foreach (entry_mem[i]) entry_mem[i] = '0;
    code_len      = 0;
    entry_len     = 0;
    in_set_mode   = 1'b0;
    need_old_code = 1'b0;
    led_on        = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_code();
    test_entry_full();
    test_code_change();
    test_random_sessions();
    test_output_hold();

    @(negedge clk);
    in_valid <= 1'b0;
    while (lock_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
